### design/scpg_pkg.sv
// scpg_pkg: widths, register indexes and fixed-point constants of the
// S-curve profile generator. No dependencies.
package scpg_pkg;

    localparam int RAMP_W   = 17;
    localparam int WSUM_W   = 25;
    localparam int WLEN_W   = 9;
    localparam int DECEL_W  = 16;
    localparam int VSCALE_W = 32;
    localparam int PSCALE_W = 25;
    localparam int LIMIT_W  = 16;
    localparam int VEL_W    = 32;
    localparam int POS_W    = 48;
    localparam int ACC_W    = 47;
    localparam int PROD_W   = 58;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_TICK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NEGATE     = 3'd6;

    localparam logic [RAMP_W-1:0]   ONE_Q16    = 17'h10000;
    localparam logic [PROD_W:0]     ROUND_HALF = 59'd32768;
    localparam logic [VEL_W-1:0]    VEL_MAX    = 32'h7FFF_FFFF;
    localparam logic [ACC_W-1:0]    POS_MAX    = 47'h7FFF_FFFF_FFFF;

endpackage

### design/s_curve_profile_generator.sv
// s_curve_profile_generator: jerk-limited velocity/position generator from a
// clamped ramp and a running window sum, on one shared multiplier.
// Depends on scpg_pkg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  in      | to block  | i_in_valid/o_in_stall | i_restart
//  out     | from block| o_out_valid/i_out_stall| o_velocity, o_position, o_done_res
//  cfg     | to block  | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// A word passes through ramp and history read, two passes through the shared
// multiplier (velocity, then position step) with rounding between, and update;
// a move that is already done goes to a hold step instead. No new word is taken until idle.
// A stalled output holds the update step until the previous result leaves.
// Reset is synchronous, active low; the ramp history memory is not cleared.
module s_curve_profile_generator #(
    parameter int MAX_WINDOW = 256,
    parameter int TICK_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_restart,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [scpg_pkg::VEL_W-1:0]     o_velocity,
    output logic signed [scpg_pkg::POS_W-1:0]     o_position,
    output logic                                  o_done_res,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [scpg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [scpg_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int W_W    = (FILL_W > scpg_pkg::WLEN_W) ? FILL_W : scpg_pkg::WLEN_W;
    localparam int TC_W   = (TICK_BITS > scpg_pkg::LIMIT_W) ? TICK_BITS : scpg_pkg::LIMIT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RAMP = 3'd1;
    localparam logic [2:0] S_VMUL = 3'd2;
    localparam logic [2:0] S_VEL  = 3'd3;
    localparam logic [2:0] S_PMUL = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_HOLD = 3'd6;

    // configuration
    logic [scpg_pkg::WLEN_W-1:0]   r_window_len;
    logic [scpg_pkg::RAMP_W-1:0]   r_ramp_step;
    logic [scpg_pkg::DECEL_W-1:0]  r_decel_tick;
    logic [scpg_pkg::VSCALE_W-1:0] r_vel_scale;
    logic [scpg_pkg::PSCALE_W-1:0] r_pos_scale;
    logic [scpg_pkg::LIMIT_W-1:0]  r_tick_limit;
    logic                          r_negate;

    // move state
    logic [2:0]                    r_state;
    logic [scpg_pkg::RAMP_W-1:0]   r_ramp_val;
    logic [scpg_pkg::WSUM_W-1:0]   r_wsum;
    logic [scpg_pkg::VEL_W-1:0]    r_prev_vel;
    logic [scpg_pkg::ACC_W-1:0]    r_accum;
    logic [TICK_BITS-1:0]          r_tick;
    logic [FILL_W-1:0]             r_fill;
    logic [PTR_W-1:0]              r_wr_ptr;
    logic                          r_finished;

    // working registers
    logic [scpg_pkg::RAMP_W-1:0]   r_ramp;
    logic [scpg_pkg::RAMP_W-1:0]   r_rd;
    logic [scpg_pkg::PROD_W-1:0]   r_prod;
    logic [scpg_pkg::VEL_W-1:0]    r_vel;
    logic                          r_out_valid;

    logic [scpg_pkg::RAMP_W-1:0]   mem [MAX_WINDOW];

    logic                          in_accept;
    logic                          out_free;
    logic                          commit;
    logic [W_W-1:0]                w_eff;
    logic [W_W:0]                  ptr_ext;
    logic [W_W:0]                  old_idx;
    logic [scpg_pkg::RAMP_W:0]     ramp_up;
    logic [scpg_pkg::RAMP_W-1:0]   n_ramp;
    logic [scpg_pkg::VSCALE_W-1:0] mul_a;
    logic [scpg_pkg::VSCALE_W-1:0] mul_b;
    logic [63:0]                   mul_p;
    logic [scpg_pkg::PROD_W:0]     rnd;
    logic [scpg_pkg::PROD_W-16:0]  rnd_q;
    logic [scpg_pkg::VEL_W-1:0]    n_vel;
    logic [scpg_pkg::ACC_W:0]      acc_sum;
    logic [scpg_pkg::ACC_W-1:0]    n_accum;
    logic                          win_full;
    logic [scpg_pkg::WSUM_W-1:0]   wsum_sub;
    logic [scpg_pkg::WSUM_W-1:0]   n_wsum;
    logic [TICK_BITS-1:0]          n_tick;
    logic                          n_finished;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = (r_state == S_UPD) && out_free;

    // effective window length, clamped to the history depth
    always_comb begin
        if (W_W'(r_window_len) > W_W'(MAX_WINDOW)) begin
            w_eff = W_W'(MAX_WINDOW);
        end else begin
            w_eff = W_W'(r_window_len);
        end
        ptr_ext = (W_W + 1)'(r_wr_ptr);
        if (ptr_ext >= (W_W + 1)'(w_eff)) begin
            old_idx = ptr_ext - (W_W + 1)'(w_eff);
        end else begin
            old_idx = ptr_ext + (W_W + 1)'(MAX_WINDOW) - (W_W + 1)'(w_eff);
        end
    end

    // first filter: clamped ramp
    always_comb begin
        ramp_up = {1'b0, r_ramp_val} + {1'b0, r_ramp_step};
        if (TC_W'(r_tick) < TC_W'(r_decel_tick)) begin
            n_ramp = (ramp_up > {1'b0, scpg_pkg::ONE_Q16}) ? scpg_pkg::ONE_Q16
                                                           : ramp_up[scpg_pkg::RAMP_W-1:0];
        end else begin
            n_ramp = (r_ramp_val > r_ramp_step) ? r_ramp_val - r_ramp_step : '0;
        end
    end

    // shared multiplier: velocity pass, then position pass
    always_comb begin
        if (r_state == S_VMUL) begin
            mul_a = scpg_pkg::VSCALE_W'({1'b0, r_wsum} + (scpg_pkg::WSUM_W + 1)'(r_ramp));
            mul_b = r_vel_scale;
        end else begin
            mul_a = r_prev_vel + r_vel;
            mul_b = scpg_pkg::VSCALE_W'(r_pos_scale);
        end
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // round half up, drop 16 fraction bits
    always_comb begin
        rnd   = {1'b0, r_prod} + scpg_pkg::ROUND_HALF;
        rnd_q = rnd[scpg_pkg::PROD_W:16];
        n_vel = (rnd_q > (scpg_pkg::PROD_W - 15)'(scpg_pkg::VEL_MAX)) ? scpg_pkg::VEL_MAX
                                                                    : rnd_q[scpg_pkg::VEL_W-1:0];
        acc_sum = {1'b0, r_accum} + (scpg_pkg::ACC_W + 1)'(rnd_q);
        n_accum = (acc_sum > {1'b0, scpg_pkg::POS_MAX}) ? scpg_pkg::POS_MAX
                                                         : acc_sum[scpg_pkg::ACC_W-1:0];
    end

    // second filter: drop the oldest ramp once the window is full, add the new one
    always_comb begin
        win_full = (W_W'(r_fill) >= w_eff);
        wsum_sub = win_full ? r_wsum - scpg_pkg::WSUM_W'(r_rd) : r_wsum;
        n_wsum   = wsum_sub + scpg_pkg::WSUM_W'(r_ramp);
        n_tick   = (r_tick != '1) ? r_tick + 1'b1 : r_tick;
        n_finished = (r_vel == '0) || (TC_W'(n_tick) > TC_W'(r_tick_limit));
    end

    // ramp history
    always_ff @(posedge i_clk) begin
        if (commit && (w_eff != '0)) begin
            mem[r_wr_ptr] <= r_ramp;
        end
        if (r_state == S_RAMP) begin
            r_rd <= mem[old_idx[PTR_W-1:0]];
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_RAMP) begin
            r_ramp <= n_ramp;
        end
        if ((r_state == S_VMUL) || (r_state == S_PMUL)) begin
            r_prod <= mul_p[scpg_pkg::PROD_W-1:0];
        end
        if (r_state == S_VEL) begin
            r_vel <= n_vel;
        end
        if (commit) begin
            o_velocity <= r_negate ? $signed(-r_vel) : $signed(r_vel);
            o_position <= r_negate ? $signed(scpg_pkg::POS_W'(0) - scpg_pkg::POS_W'(n_accum))
                                   : $signed(scpg_pkg::POS_W'(n_accum));
            o_done_res <= n_finished;
        end else if ((r_state == S_HOLD) && out_free) begin
            o_velocity <= r_negate ? $signed(-r_prev_vel) : $signed(r_prev_vel);
            o_position <= r_negate ? $signed(scpg_pkg::POS_W'(0) - scpg_pkg::POS_W'(r_accum))
                                   : $signed(scpg_pkg::POS_W'(r_accum));
            o_done_res <= r_finished;
        end
    end

    // control, configuration and move state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_window_len <= scpg_pkg::WLEN_W'(1);
            r_ramp_step  <= scpg_pkg::ONE_Q16;
            r_decel_tick <= '0;
            r_vel_scale  <= '0;
            r_pos_scale  <= '0;
            r_tick_limit <= scpg_pkg::LIMIT_W'(1);
            r_negate     <= 1'b0;
            r_ramp_val   <= '0;
            r_wsum       <= '0;
            r_prev_vel   <= '0;
            r_accum      <= '0;
            r_tick       <= '0;
            r_fill       <= '0;
            r_wr_ptr     <= '0;
            r_finished   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    scpg_pkg::REG_WINDOW_LEN: r_window_len <= i_cfg_data[scpg_pkg::WLEN_W-1:0];
                    scpg_pkg::REG_RAMP_STEP:  r_ramp_step  <= i_cfg_data[scpg_pkg::RAMP_W-1:0];
                    scpg_pkg::REG_DECEL_TICK: r_decel_tick <= i_cfg_data[scpg_pkg::DECEL_W-1:0];
                    scpg_pkg::REG_VEL_SCALE:  r_vel_scale  <= i_cfg_data[scpg_pkg::VSCALE_W-1:0];
                    scpg_pkg::REG_POS_SCALE:  r_pos_scale  <= i_cfg_data[scpg_pkg::PSCALE_W-1:0];
                    scpg_pkg::REG_TICK_LIMIT: r_tick_limit <= i_cfg_data[scpg_pkg::LIMIT_W-1:0];
                    scpg_pkg::REG_NEGATE:     r_negate     <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_restart) begin
                            r_ramp_val <= '0;
                            r_wsum     <= '0;
                            r_prev_vel <= '0;
                            r_accum    <= '0;
                            r_tick     <= '0;
                            r_fill     <= '0;
                            r_wr_ptr   <= '0;
                            r_finished <= 1'b0;
                        end
                        r_state <= (i_restart || !r_finished) ? S_RAMP : S_HOLD;
                    end
                end
                S_RAMP: r_state <= S_VMUL;
                S_VMUL: r_state <= S_VEL;
                S_VEL:  r_state <= S_PMUL;
                S_PMUL: r_state <= S_UPD;
                S_UPD: begin
                    // hold until the previous word leaves the output register
                    if (out_free) begin
                        r_accum    <= n_accum;
                        r_ramp_val <= r_ramp;
                        r_prev_vel <= r_vel;
                        r_tick     <= n_tick;
                        r_finished <= n_finished;
                        if (w_eff != '0) begin
                            r_wsum <= n_wsum;
                            if (!win_full) begin
                                r_fill <= r_fill + 1'b1;
                            end
                            r_wr_ptr <= (r_wr_ptr == PTR_W'(MAX_WINDOW - 1)) ? '0
                                                                            : r_wr_ptr + 1'b1;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### design/scpg_checker.sv
// scpg_checker: port-level checks of the S-curve profile generator, bound to
// the top level. Depends on scpg_pkg.
module scpg_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  i_restart,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [scpg_pkg::VEL_W-1:0]     o_velocity,
    input logic signed [scpg_pkg::POS_W-1:0]     o_position,
    input logic                                  o_done_res,
    input logic                                  i_cfg_valid,
    input logic                                  o_cfg_ready,
    input logic [scpg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input logic [scpg_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_velocity)
            && $stable(o_position) && $stable(o_done_res))
        else $error("output word changed under stall");

    // an accepted word keeps the block busy on the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block ready right after accepting a word");

    // zero velocity always finishes the move
    a_zero_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_velocity == '0) |-> o_done_res)
        else $error("zero velocity without done");

    // a new result appears as the block turns ready again
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall && o_cfg_ready)
        else $error("result raised while block busy");

endmodule

bind s_curve_profile_generator scpg_checker u_scpg_checker (.*);
